/* design/pswm_pkg.sv */
// ----------------------------------------------------------------------------
// pswm_pkg
// Shared types of the pivot swap map builder: row index, row pair and the
// item class that the front end hands to the back end.
// ----------------------------------------------------------------------------
package pswm_pkg;

	localparam int ROW_W          = 31;
	localparam int MAX_PIVOTS_DEF = 32;

	typedef logic [ROW_W-1:0] row_t;

	typedef struct packed {
		row_t src;
		row_t dst;
	} pair_t;

	typedef struct packed {
		logic first;
		logic same;
		logic last;
	} kind_t;

endpackage

/* design/pswm_if.sv */
// ----------------------------------------------------------------------------
// pswm_if
// Valid/ready channels of the pivot swap map builder: pivot words in,
// row pair words out, and the first-row register write.
// ----------------------------------------------------------------------------
interface pswm_in_if;
	logic               valid;
	logic               ready;
	pswm_pkg::row_t     pivot_row;
	logic               last_pivot;

	modport source (output valid, pivot_row, last_pivot, input ready);
	modport sink   (input valid, pivot_row, last_pivot, output ready);
endinterface

interface pswm_out_if;
	logic               valid;
	logic               ready;
	pswm_pkg::row_t     source_row;
	pswm_pkg::row_t     dest_row;
	logic               last_pair;

	modport source (output valid, source_row, dest_row, last_pair, input ready);
	modport sink   (input valid, source_row, dest_row, last_pair, output ready);
endinterface

interface pswm_cfg_if;
	logic               valid;
	logic               ready;
	pswm_pkg::row_t     first_row;

	modport source (output valid, first_row, input ready);
	modport sink   (input valid, first_row, output ready);
endinterface

/* design/pswm_ram.sv */
// ----------------------------------------------------------------------------
// pswm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pswm_ram #(
	parameter int  WIDTH  = 1,
	parameter int  DEPTH  = 2,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* design/pswm_front.sv */
// ----------------------------------------------------------------------------
// pswm_front
// Accepts pivot words, numbers them within the panel, forms the source row
// and classifies each item before it enters the work queue.
// ----------------------------------------------------------------------------
module pswm_front #(
	parameter int  MAX_PIVOTS = pswm_pkg::MAX_PIVOTS_DEF,
	localparam int PIV_W      = (MAX_PIVOTS > 1) ? $clog2(MAX_PIVOTS) : 1,
	localparam int ENT_W      = $bits(pswm_pkg::kind_t) + PIV_W + $bits(pswm_pkg::pair_t)
) (
	input  logic             clk,
	input  logic             arst_n,
	pswm_in_if.sink          pivots,
	pswm_cfg_if.sink         cfg,
	input  logic             q_full,
	output logic             q_push,
	output logic [ENT_W-1:0] q_data
);

	pswm_pkg::row_t  first_row_q;
	logic [PIV_W-1:0] piv_idx_q;
	pswm_pkg::row_t  src;
	pswm_pkg::kind_t kind;
	logic            take;

	assign cfg.ready    = 1'b1;
	assign pivots.ready = !q_full;
	assign take         = pivots.valid && !q_full;
	assign q_push       = take;
	assign src          = first_row_q + pswm_pkg::row_t'(piv_idx_q);

	always_comb begin
		kind.first = (piv_idx_q == '0);
		kind.same  = (src == pivots.pivot_row);
		kind.last  = pivots.last_pivot || (piv_idx_q == PIV_W'(MAX_PIVOTS - 1));
	end

	assign q_data = {kind, piv_idx_q, src, pivots.pivot_row};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_row_q <= '0;
			piv_idx_q   <= '0;
		end else begin
			if (cfg.valid) begin
				first_row_q <= cfg.first_row;
			end
			if (take) begin
				piv_idx_q <= kind.last ? '0 : piv_idx_q + 1'b1;
			end
		end
	end

endmodule

/* design/pswm_queue.sv */
// ----------------------------------------------------------------------------
// pswm_queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module pswm_queue #(
	parameter int WIDTH = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic             valid,
	output logic [WIDTH-1:0] dout
);

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] ent_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign valid = (cnt_q != '0);
	assign dout  = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= din;
		end
	end

endmodule

/* design/pswm_back.sv */
// ----------------------------------------------------------------------------
// pswm_back
// Carries out one classified pivot against the pair table: scans stored
// destinations, redirects or appends pairs, swaps the pair ending at the
// panel row into its slot, and streams the table out at the end of a panel.
// ----------------------------------------------------------------------------
module pswm_back #(
	parameter int  MAX_PIVOTS = pswm_pkg::MAX_PIVOTS_DEF,
	localparam int PIV_W      = (MAX_PIVOTS > 1) ? $clog2(MAX_PIVOTS) : 1,
	localparam int ENT_W      = $bits(pswm_pkg::kind_t) + PIV_W + $bits(pswm_pkg::pair_t)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  logic [ENT_W-1:0] q_data,
	output logic             q_pop,
	pswm_out_if.source       pairs
);

	localparam int DEPTH = 2 * MAX_PIVOTS;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef enum logic [12:0] {
		S_IDLE  = 13'b0000000000001,
		S_INIT0 = 13'b0000000000010,
		S_INIT1 = 13'b0000000000100,
		S_SRCH  = 13'b0000000001000,
		S_WR1   = 13'b0000000010000,
		S_WR2   = 13'b0000000100000,
		S_RDI   = 13'b0000001000000,
		S_SWA   = 13'b0000010000000,
		S_SWB   = 13'b0000100000000,
		S_FIN   = 13'b0001000000000,
		S_ERD   = 13'b0010000000000,
		S_ELD   = 13'b0100000000000,
		S_EOUT  = 13'b1000000000000
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                out_valid_q;

	pswm_pkg::kind_t     in_kind;
	logic [PIV_W-1:0]    in_idx;
	pswm_pkg::pair_t     in_pair;

	pswm_pkg::kind_t     kind_q;
	logic [PIV_W-1:0]    idx_q;
	pswm_pkg::pair_t     item_q;
	logic [IDX_W-1:0]    p_q;
	logic                hs_q;
	logic                hd_q;
	logic [IDX_W-1:0]    fs_q;
	logic [IDX_W-1:0]    fd_q;
	pswm_pkg::row_t      fs_src_q;
	pswm_pkg::row_t      fd_src_q;
	logic [IDX_W-1:0]    lst_q;
	pswm_pkg::pair_t     lst_ent_q;
	logic [1:0]          add_q;
	logic [IDX_W-1:0]    k_q;
	pswm_pkg::pair_t     out_q;
	logic                out_last_q;

	logic                ram_we;
	logic [IDX_W-1:0]    ram_waddr;
	pswm_pkg::pair_t     ram_wdata;
	logic [IDX_W-1:0]    ram_raddr;
	logic [$bits(pswm_pkg::pair_t)-1:0] ram_rdata;
	pswm_pkg::pair_t     rd;

	logic                m_src;
	logic                m_dst;
	logic                hs_n;
	logic                hd_n;
	logic                scan_end;
	logic [IDX_W-1:0]    cnt_idx;
	logic [IDX_W-1:0]    cnt_add_idx;
	logic [IDX_W-1:0]    idx_slot;

	assign {in_kind, in_idx, in_pair} = q_data;
	assign rd = pswm_pkg::pair_t'(ram_rdata);

	pswm_ram #(
		.WIDTH ($bits(pswm_pkg::pair_t)),
		.DEPTH (DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign q_pop = (state_q == S_IDLE) && q_valid;

	assign m_src       = (rd.dst == item_q.src);
	assign m_dst       = !m_src && (rd.dst == item_q.dst);
	assign hs_n        = hs_q || m_src;
	assign hd_n        = hd_q || m_dst;
	assign scan_end    = (hs_n && (hd_n || kind_q.same)) || (CNT_W'(p_q) + 1'b1 >= cnt_q);
	assign cnt_idx     = IDX_W'(cnt_q);
	assign cnt_add_idx = IDX_W'(cnt_q + CNT_W'(add_q));
	assign idx_slot    = IDX_W'(idx_q);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = item_q;
		ram_raddr = '0;
		case (state_q)
			S_INIT0: begin
				ram_we    = 1'b1;
				ram_wdata = '{src: item_q.dst, dst: item_q.src};
			end
			S_INIT1: begin
				ram_we    = 1'b1;
				ram_waddr = IDX_W'(1);
			end
			S_SRCH: begin
				ram_raddr = p_q + 1'b1;
			end
			S_WR1: begin
				if (!hs_q) begin
					ram_we    = 1'b1;
					ram_waddr = cnt_idx;
				end else if (!kind_q.same) begin
					ram_we    = 1'b1;
					ram_waddr = fs_q;
					ram_wdata = '{src: fs_src_q, dst: item_q.dst};
				end
			end
			S_WR2: begin
				ram_we = 1'b1;
				if (!hd_q) begin
					ram_waddr = cnt_add_idx;
					ram_wdata = '{src: item_q.dst, dst: item_q.src};
				end else begin
					ram_waddr = fd_q;
					ram_wdata = '{src: fd_src_q, dst: item_q.src};
				end
			end
			S_RDI: begin
				ram_raddr = idx_slot;
			end
			S_SWA: begin
				ram_we    = 1'b1;
				ram_waddr = lst_q;
				ram_wdata = rd;
			end
			S_SWB: begin
				ram_we    = 1'b1;
				ram_waddr = idx_slot;
				ram_wdata = lst_ent_q;
			end
			S_ERD: begin
				ram_raddr = k_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						if (in_kind.first) begin
							state_q <= S_INIT0;
						end else if (cnt_q == '0) begin
							state_q <= S_WR1;
						end else begin
							state_q <= S_SRCH;
						end
					end
				end
				S_INIT0: begin
					cnt_q   <= CNT_W'(1);
					state_q <= kind_q.same ? S_FIN : S_INIT1;
				end
				S_INIT1: begin
					cnt_q   <= CNT_W'(2);
					state_q <= S_FIN;
				end
				S_SRCH: begin
					if (scan_end) begin
						state_q <= S_WR1;
					end
				end
				S_WR1: begin
					state_q <= kind_q.same ? S_RDI : S_WR2;
				end
				S_WR2: begin
					state_q <= S_RDI;
				end
				S_RDI: begin
					state_q <= (lst_q == idx_slot) ? S_FIN : S_SWA;
				end
				S_SWA: begin
					state_q <= S_SWB;
				end
				S_SWB: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					cnt_q   <= cnt_q + CNT_W'(add_q);
					state_q <= kind_q.last ? S_ERD : S_IDLE;
				end
				S_ERD: begin
					state_q <= S_ELD;
				end
				S_ELD: begin
					out_valid_q <= 1'b1;
					state_q     <= S_EOUT;
				end
				S_EOUT: begin
					if (pairs.ready) begin
						out_valid_q <= 1'b0;
						if (out_last_q) begin
							cnt_q   <= '0;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_ERD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (q_valid) begin
					kind_q <= in_kind;
					idx_q  <= in_idx;
					item_q <= in_pair;
					p_q    <= '0;
					hs_q   <= 1'b0;
					hd_q   <= 1'b0;
					add_q  <= '0;
					k_q    <= '0;
				end
			end
			S_SRCH: begin
				hs_q <= hs_n;
				hd_q <= hd_n;
				if (m_src) begin
					fs_q     <= p_q;
					fs_src_q <= rd.src;
				end
				if (m_dst) begin
					fd_q     <= p_q;
					fd_src_q <= rd.src;
				end
				p_q <= p_q + 1'b1;
			end
			S_WR1: begin
				add_q <= hs_q ? 2'd0 : 2'd1;
				if (kind_q.same) begin
					lst_q     <= hs_q ? fs_q : cnt_idx;
					lst_ent_q <= hs_q ? pswm_pkg::pair_t'{src: fs_src_q, dst: item_q.dst}
					                  : item_q;
				end
			end
			S_WR2: begin
				if (!hd_q) begin
					lst_q     <= cnt_add_idx;
					lst_ent_q <= '{src: item_q.dst, dst: item_q.src};
					add_q     <= add_q + 2'd1;
				end else begin
					lst_q     <= fd_q;
					lst_ent_q <= '{src: fd_src_q, dst: item_q.src};
				end
			end
			S_ELD: begin
				out_q      <= rd;
				out_last_q <= (CNT_W'(k_q) + 1'b1 == cnt_q);
			end
			S_EOUT: begin
				if (pairs.ready) begin
					k_q <= k_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign pairs.valid      = out_valid_q;
	assign pairs.source_row = out_q.src;
	assign pairs.dest_row   = out_q.dst;
	assign pairs.last_pair  = out_last_q;

endmodule

/* design/pivot_swap_map_builder_unit.sv */
// ----------------------------------------------------------------------------
// pivot_swap_map_builder_unit
// Table scan: a panel's first pivot writes its pairs unscanned; pivot i scans
//   up to pair_count entries, one per cycle, pair_count <= 2*i.
// Emission: one table read per row pair word, held until pairs.ready.
// Front end keeps taking up to two pivot words while the back end works.
// Reset: control clears at once; the pair table is not cleared.
// ----------------------------------------------------------------------------
module pivot_swap_map_builder_unit #(
	parameter int MAX_PIVOTS = pswm_pkg::MAX_PIVOTS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	pswm_in_if.sink    pivots,
	pswm_cfg_if.sink   cfg,
	pswm_out_if.source pairs
);

	localparam int PIV_W = (MAX_PIVOTS > 1) ? $clog2(MAX_PIVOTS) : 1;
	localparam int ENT_W = $bits(pswm_pkg::kind_t) + PIV_W + $bits(pswm_pkg::pair_t);

	logic             q_push;
	logic             q_full;
	logic             q_pop;
	logic             q_valid;
	logic [ENT_W-1:0] q_din;
	logic [ENT_W-1:0] q_dout;

	pswm_front #(
		.MAX_PIVOTS (MAX_PIVOTS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.pivots (pivots),
		.cfg    (cfg),
		.q_full (q_full),
		.q_push (q_push),
		.q_data (q_din)
	);

	pswm_queue #(
		.WIDTH (ENT_W)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.full   (q_full),
		.pop    (q_pop),
		.valid  (q_valid),
		.dout   (q_dout)
	);

	pswm_back #(
		.MAX_PIVOTS (MAX_PIVOTS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_data  (q_dout),
		.q_pop   (q_pop),
		.pairs   (pairs)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("pivot word pushed into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("back end popped empty queue");

	a_no_pop_emit: assert property (@(posedge clk) disable iff (!arst_n)
		pairs.valid |-> !q_pop)
		else $error("back end took a pivot while emitting pairs");

endmodule
